[rtl/lfu_pkg.sv]
`timescale 1ns / 1ps
// lfu_pkg: shared types and constants for the LFU cache table.
// Used by lfu_cache_table and the testbench; depends on nothing.
package lfu_pkg;

	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_COUNT_BITS = 16;
	localparam int CAP_W          = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETTLE,
		ST_DECIDE,
		ST_UPDATE,
		ST_FLUSH,
		ST_DONE
	} state_t;

endpackage

[rtl/lfu_mem.sv]
`timescale 1ns / 1ps
// lfu_mem: entry store, one write port and one read port, registered read data.
// Plain array; no dependencies.
module lfu_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 84
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/lfu_scan.sv]
`timescale 1ns / 1ps
// lfu_scan: walks the entries one per cycle, tracking the key match, the
// replacement victim and the first free slot. Uses no package items.
module lfu_scan #(
	parameter int IW = 4,
	parameter int CW = 16,
	parameter int RW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          vld,
	input  logic          ent_valid,
	input  logic [IW-1:0] idx,
	input  logic [31:0]   key,
	input  logic [31:0]   e_key,
	input  logic [31:0]   e_val,
	input  logic [CW-1:0] e_cnt,
	input  logic [RW-1:0] e_rank,
	output logic          match_q,
	output logic [IW-1:0] match_idx_q,
	output logic [31:0]   match_val_q,
	output logic [CW-1:0] match_cnt_q,
	output logic [RW-1:0] match_rank_q,
	output logic [IW-1:0] vic_idx_q,
	output logic [31:0]   vic_key_q,
	output logic [RW-1:0] vic_rank_q,
	output logic [IW-1:0] free_idx_q
);

	logic          vic_found_q;
	logic          free_found_q;
	logic [CW-1:0] vic_cnt_q;
	logic          take_vic;

	// lowest count wins, older entry wins a tie; first one seen starts it
	assign take_vic = ent_valid && (!vic_found_q || e_cnt < vic_cnt_q ||
		(e_cnt == vic_cnt_q && e_rank > vic_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			match_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (vld) begin
			if (ent_valid && !match_q && e_key == key) begin
				match_q <= 1'b1;
			end
			if (take_vic) begin
				vic_found_q <= 1'b1;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld) begin
			if (ent_valid && !match_q && e_key == key) begin
				match_idx_q  <= idx;
				match_val_q  <= e_val;
				match_cnt_q  <= e_cnt;
				match_rank_q <= e_rank;
			end
			if (take_vic) begin
				vic_idx_q  <= idx;
				vic_key_q  <= e_key;
				vic_cnt_q  <= e_cnt;
				vic_rank_q <= e_rank;
			end
			if (!ent_valid && !free_found_q) begin
				free_idx_q <= idx;
			end
		end
	end

endmodule

[rtl/lfu_cache_table.sv]
`timescale 1ns / 1ps
// lfu_cache_table: top level of the LFU key/value cache with LRU tie break.
// Depends on lfu_pkg, lfu_mem and lfu_scan.
//
// One transaction at a time: a get or put scans the entry memory (one read per
// cycle through its single read port), settles and decides, and, on a hit or
// an insert, passes over the entries again to rewrite the recency ranks and
// flushes, before the result is handed to the output register; a miss that
// inserts nothing skips the rewrite pass.
// The next request is taken while the previous result still waits on a
// stalled output. Valid bits sit in flip-flops; entry data is never cleared.
module lfu_cache_table #(
	parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  lfu_pkg::req_t            in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output lfu_pkg::rsp_t            out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW    = IW;
	localparam int OW    = $clog2(ENTRIES + 1);
	localparam int EW    = 64 + COUNT_BITS + RW;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	lfu_pkg::state_t state_q, state_d;

	logic [IW-1:0]            addr_q;
	logic                     scan_s1, upd_s1;
	logic [IW-1:0]            idx_s1;
	lfu_pkg::req_t            req_q;
	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic [OW-1:0]            occ_q;
	logic [ENTRIES-1:0]       valid_q;
	lfu_pkg::rsp_t            res_q;
	lfu_pkg::rsp_t            res_hold_q;
	logic                     out_valid_q;
	logic [IW-1:0]            target_q;
	logic [RW:0]              thr_q;
	logic [EW-1:0]            new_ent_q;

	logic          rd_en, wr_en;
	logic [EW-1:0] rd_data, wr_data;

	logic [31:0]         e_key, e_val;
	logic [COUNT_BITS-1:0] e_cnt;
	logic [RW-1:0]       e_rank;

	logic          match;
	logic [IW-1:0] match_idx, vic_idx, free_idx;
	logic [31:0]   match_val, vic_key;
	logic [COUNT_BITS-1:0] match_cnt;
	logic [RW-1:0] match_rank, vic_rank;

	logic          is_put, ins, evict, full, upd, out_free, last;
	logic [IW-1:0] target;
	logic [RW:0]   thr;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [31:0]   new_val;
	lfu_pkg::rsp_t res_d;
	logic          bump;

	assign e_key  = rd_data[EW-1 -: 32];
	assign e_val  = rd_data[EW-33 -: 32];
	assign e_cnt  = rd_data[RW +: COUNT_BITS];
	assign e_rank = rd_data[RW-1:0];

	lfu_mem #(
		.DEPTH (ENTRIES),
		.AW    (IW),
		.DW    (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_data)
	);

	lfu_scan #(
		.IW (IW),
		.CW (COUNT_BITS),
		.RW (RW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (state_q == lfu_pkg::ST_IDLE),
		.vld          (scan_s1),
		.ent_valid    (valid_q[idx_s1]),
		.idx          (idx_s1),
		.key          (req_q.key),
		.e_key        (e_key),
		.e_val        (e_val),
		.e_cnt        (e_cnt),
		.e_rank       (e_rank),
		.match_q      (match),
		.match_idx_q  (match_idx),
		.match_val_q  (match_val),
		.match_cnt_q  (match_cnt),
		.match_rank_q (match_rank),
		.vic_idx_q    (vic_idx),
		.vic_key_q    (vic_key),
		.vic_rank_q   (vic_rank),
		.free_idx_q   (free_idx)
	);

	// decision from the finished scan
	always_comb begin
		is_put  = (req_q.opcode == lfu_pkg::OP_PUT);
		full    = (32'(occ_q) >= 32'(cap_q)) || (32'(occ_q) >= 32'(ENTRIES));
		ins     = is_put && !match && (cap_q != '0);
		evict   = ins && full;
		upd     = match || ins;
		target  = match ? match_idx : (evict ? vic_idx : free_idx);
		thr     = match ? {1'b0, match_rank} :
			(evict ? {1'b0, vic_rank} : (RW+1)'(occ_q));
		new_cnt = match ? ((match_cnt == '1) ? match_cnt : match_cnt + 1'b1) :
			COUNT_BITS'(1);
		new_val = (match && !is_put) ? match_val : req_q.value;
		res_d.hit         = match;
		res_d.read_value  = is_put ? 32'sd0 : (match ? match_val : -32'sd1);
		res_d.evicted     = evict;
		res_d.evicted_key = evict ? vic_key : 32'sd0;
	end

	// rank rewrite: target gets the new entry, younger entries age by one
	always_comb begin
		bump    = valid_q[idx_s1] && ({1'b0, e_rank} < thr_q);
		wr_en   = upd_s1 && (idx_s1 == target_q || bump);
		wr_data = (idx_s1 == target_q) ? new_ent_q :
			{rd_data[EW-1:RW], e_rank + 1'b1};
	end

	assign last     = (addr_q == LAST);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfu_pkg::ST_IDLE:   if (in_valid) state_d = lfu_pkg::ST_SCAN;
			lfu_pkg::ST_SCAN:   if (last) state_d = lfu_pkg::ST_SETTLE;
			lfu_pkg::ST_SETTLE: state_d = lfu_pkg::ST_DECIDE;
			lfu_pkg::ST_DECIDE: state_d = upd ? lfu_pkg::ST_UPDATE : lfu_pkg::ST_DONE;
			lfu_pkg::ST_UPDATE: if (last) state_d = lfu_pkg::ST_FLUSH;
			lfu_pkg::ST_FLUSH:  state_d = lfu_pkg::ST_DONE;
			lfu_pkg::ST_DONE:   if (out_free) state_d = lfu_pkg::ST_IDLE;
			default:            state_d = lfu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		unique case (state_q)
			lfu_pkg::ST_IDLE:   in_stall = 1'b0;
			lfu_pkg::ST_SCAN,
			lfu_pkg::ST_UPDATE: rd_en = 1'b1;
			default:            ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfu_pkg::ST_IDLE;
			addr_q      <= '0;
			scan_s1     <= 1'b0;
			upd_s1      <= 1'b0;
			cap_q       <= lfu_pkg::CAP_RESET;
			occ_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == lfu_pkg::ST_SCAN);
			upd_s1  <= (state_q == lfu_pkg::ST_UPDATE);
			if (rd_en) begin
				addr_q <= last ? '0 : addr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (state_q == lfu_pkg::ST_DECIDE && ins) begin
				valid_q[target] <= 1'b1;
				if (!evict) begin
					occ_q <= occ_q + 1'b1;
				end
			end
			if (state_q == lfu_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (in_valid && !in_stall) begin
			req_q <= in_data;
		end
		if (state_q == lfu_pkg::ST_DECIDE) begin
			target_q   <= target;
			thr_q      <= thr;
			new_ent_q  <= {req_q.key, new_val, new_cnt, RW'(0)};
			res_hold_q <= res_d;
		end
	end

	// result register may only be reloaded once the old result has gone
	always_ff @(posedge clk) begin
		if (state_q == lfu_pkg::ST_DONE && out_free) begin
			res_q <= res_hold_q;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(ENTRIES))
		else $error("occupancy above table size");

	a_occ_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy disagrees with valid bits");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.evicted && res_q.hit))
		else $error("eviction reported on a hit");

	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_s1 |-> !wr_en)
		else $error("memory written during lookup pass");

endmodule

[tb/tb_lfu_cache_table.sv]
`timescale 1ns / 1ps
// tb_lfu_cache_table: self-checking testbench for the LFU cache table.
// Depends on lfu_pkg and lfu_cache_table; a scoreboard class predicts each result.

class lfu_scoreboard;
	bit          ent_valid [16];
	logic [31:0] ent_key   [16];
	logic [31:0] ent_value [16];
	logic [15:0] ent_uses  [16];
	logic [3:0]  ent_rank  [16];
	int unsigned occupancy;
	logic [4:0]  capacity;
	lfu_pkg::rsp_t pending[$];
	int mismatches;
	int results_seen;

	function void clear_table();
		for (int i = 0; i < 16; i++) begin
			ent_valid[i] = 0;
			ent_key[i] = '0;
			ent_value[i] = '0;
			ent_uses[i] = '0;
			ent_rank[i] = '0;
		end
		occupancy = 0;
		capacity = lfu_pkg::CAP_RESET;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function void promote(int slot);
		logic [3:0] old;
		old = ent_rank[slot];
		for (int i = 0; i < 16; i++)
			if (ent_valid[i] && i != slot && ent_rank[i] < old)
				ent_rank[i]++;
		ent_rank[slot] = 0;
	endfunction

	function void bump_uses(int slot);
		if (ent_uses[slot] != 16'hFFFF)
			ent_uses[slot]++;
	endfunction

	// Lowest use count wins; the oldest entry breaks a tie.
	function int pick_victim();
		int best;
		best = -1;
		for (int i = 0; i < 16; i++) begin
			if (!ent_valid[i])
				continue;
			if (best < 0 || ent_uses[i] < ent_uses[best] ||
			    (ent_uses[i] == ent_uses[best] && ent_rank[i] > ent_rank[best]))
				best = i;
		end
		return best;
	endfunction

	function void note_request(lfu_pkg::req_t req);
		lfu_pkg::rsp_t r;
		int slot, target, victim;
		int unsigned cap;
		logic [3:0] vr;
		r = '0;
		slot = -1;
		target = -1;
		cap = (capacity < 16) ? capacity : 16;
		for (int i = 0; i < 16; i++)
			if (slot < 0 && ent_valid[i] && ent_key[i] == req.key)
				slot = i;
		if (req.opcode == lfu_pkg::OP_GET) begin
			if (slot >= 0) begin
				r.hit = 1;
				r.read_value = ent_value[slot];
				bump_uses(slot);
				promote(slot);
			end else begin
				r.read_value = -1;
			end
		end else if (slot >= 0) begin
			r.hit = 1;
			ent_value[slot] = req.value;
			bump_uses(slot);
			promote(slot);
		end else if (cap > 0) begin
			if (occupancy >= cap) begin
				victim = pick_victim();
				if (victim >= 0) begin
					r.evicted = 1;
					r.evicted_key = ent_key[victim];
					vr = ent_rank[victim];
					ent_valid[victim] = 0;
					for (int i = 0; i < 16; i++)
						if (ent_valid[i] && ent_rank[i] > vr)
							ent_rank[i]--;
					if (occupancy > 0)
						occupancy--;
					target = victim;
				end
			end
			for (int i = 0; i < 16; i++)
				if (target < 0 && !ent_valid[i])
					target = i;
			if (target >= 0) begin
				for (int i = 0; i < 16; i++)
					if (ent_valid[i])
						ent_rank[i]++;
				ent_valid[target] = 1;
				ent_key[target] = req.key;
				ent_value[target] = req.value;
				ent_uses[target] = 1;
				ent_rank[target] = 0;
				occupancy++;
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(lfu_pkg::rsp_t got);
		lfu_pkg::rsp_t want;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h with nothing pending", got);
			return;
		end
		want = pending.pop_front();
		if (got.hit !== want.hit || got.read_value !== want.read_value ||
		    got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch #%0d: expected hit=%b rv=%h ev=%b evk=%h,",
				          " got hit=%b rv=%h ev=%b evk=%h"},
				         mismatches, want.hit, want.read_value, want.evicted,
				         want.evicted_key, got.hit, got.read_value, got.evicted,
				         got.evicted_key);
		end
	endfunction
endclass

module tb_lfu_cache_table;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	lfu_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	lfu_pkg::rsp_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [lfu_pkg::CAP_W-1:0] cfg_data = '0;

	lfu_scoreboard sb;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	bit quiet_phase = 0;
	bit hold_off_req = 0;
	logic [31:0] key_pool [8];

	lfu_cache_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("lfu_cache_table regression: fail");
			$finish;
		end
	end

	// Check each result transaction at the rising edge.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	// Receiver back-pressure: random, with a long hold-off on request.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
				hold_off_req = 0;
				out_stall <= 0;
			end else begin
				out_stall <= (!quiet_phase && $urandom_range(99) < 29);
			end
		end
	end

	task automatic send_request(input logic op, input logic [31:0] k, input logic [31:0] v);
		@(negedge clk);
		while (!quiet_phase && $urandom_range(99) < 29)
			@(negedge clk);
		in_valid <= 1;
		in_data <= '{opcode: op, key: k, value: v};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request('{opcode: op, key: k, value: v});
		items_sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
		drain();
		cfg_valid <= 1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.capacity = cap;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Mostly reuse a small key pool so hits, updates and evictions happen.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(9) < 8)
			return key_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	task automatic random_burst(input int n, input int pool_span);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0)
				send_request(lfu_pkg::OP_PUT, pick_key(), $urandom);
			else if ($urandom_range(1) == 0)
				send_request(lfu_pkg::OP_GET, pick_key(), $urandom);
			else
				send_request(lfu_pkg::OP_PUT, key_pool[$urandom_range(pool_span)],
				             $urandom);
		end
	endtask

	initial begin
		sb = new();
		sb.clear_table();
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, hits, misses, update, eviction, capacity zero.
		send_request(lfu_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0);
		send_request(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
		write_capacity(5'd2);
		send_request(lfu_pkg::OP_PUT, 32'h0, 32'h1234_5678);
		send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
		send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
		write_capacity(5'd1);
		send_request(lfu_pkg::OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
		send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0);
		write_capacity(5'd0);
		send_request(lfu_pkg::OP_PUT, 32'h1111_1111, 32'h2);
		send_request(lfu_pkg::OP_GET, 32'h1111_1111, 32'h0);
		send_request(lfu_pkg::OP_PUT, 32'h5555_AAAA, 32'h3);
		send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0);
		write_capacity(5'd31);
		for (int i = 0; i < 4; i++)
			send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0);

		// Random phases over several capacities.
		write_capacity(5'd16);
		random_burst(120, 7);
		write_capacity(5'd4);
		random_burst(100, 7);
		// Lower capacity below occupancy.
		write_capacity(5'd3);
		random_burst(60, 7);
		// Long receiver hold-off while the sender keeps offering.
		hold_off_req = 1;
		random_burst(20, 7);
		// Pause until every expected result is in, then run at capacity zero.
		write_capacity(5'd0);
		random_burst(40, 7);
		write_capacity(5'd20);
		quiet_phase = 1;
		random_burst(100, 7);
		quiet_phase = 0;
		write_capacity(5'd1);
		random_burst(60, 7);
		write_capacity(5'd8);
		random_burst(100, 7);
		// Repeated gets on two keys push their use counts up.
		for (int i = 0; i < 20; i++)
			send_request(lfu_pkg::OP_GET, key_pool[$urandom_range(1)], 32'h0);

		drain();
		$display("covered %0d requests, %0d results, capacities 0..31 incl. saturation of capacity",
		         items_sent, sb.results_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("lfu_cache_table regression: pass");
		else
			$display("lfu_cache_table regression: fail");
		$finish;
	end
endmodule
